[hw/rtl/lie_pkg.sv]
// load instruction executor: shared types, op codes and a helper function
// used by the decoder, the memory wrapper and the top level; no dependencies
package lie_pkg;

    // load forms
    localparam logic [4:0] OP_ST_A16_SP  = 5'd0;
    localparam logic [4:0] OP_ST_A16_R   = 5'd1;
    localparam logic [4:0] OP_ST_HLD_R   = 5'd2;
    localparam logic [4:0] OP_ST_HLI_R   = 5'd3;
    localparam logic [4:0] OP_LD_RR_D16  = 5'd4;
    localparam logic [4:0] OP_LD_RR_RR   = 5'd5;
    localparam logic [4:0] OP_LD_RR_SPE  = 5'd6;
    localparam logic [4:0] OP_ST_RR_D8   = 5'd7;
    localparam logic [4:0] OP_ST_RR_R    = 5'd8;
    localparam logic [4:0] OP_LD_R_A16   = 5'd9;
    localparam logic [4:0] OP_LD_R_D8    = 5'd10;
    localparam logic [4:0] OP_LD_R_HLD   = 5'd11;
    localparam logic [4:0] OP_LD_R_HLI   = 5'd12;
    localparam logic [4:0] OP_LD_R_RR    = 5'd13;
    localparam logic [4:0] OP_LD_R_R     = 5'd14;
    localparam logic [4:0] OP_LD_R_HIGH  = 5'd15;
    localparam logic [4:0] OP_ST_HIGH_R  = 5'd16;

    // memory access kinds
    localparam logic [1:0] ACC_NONE  = 2'd0;
    localparam logic [1:0] ACC_READ  = 2'd1;
    localparam logic [1:0] ACC_BYTE  = 2'd2;
    localparam logic [1:0] ACC_WORD  = 2'd3;

    // register indexes
    localparam logic [2:0] REG_C = 3'd1;
    localparam logic [2:0] REG_F = 3'd6;
    localparam logic [1:0] PAIR_HL = 2'd2;
    localparam logic [1:0] PAIR_SP = 2'd3;

    localparam logic [15:0] HIGH_PAGE = 16'hff00;

    // packed stream widths
    localparam int IN_BITS  = 32;
    localparam int OUT_BITS = 56;

    typedef logic [7:0][7:0] t_regs;

    // one result transaction
    typedef struct packed {
        logic [1:0]  mem_access;
        logic [15:0] mem_address;
        logic [15:0] mem_value;
        logic [15:0] dest_value;
        logic [3:0]  flags;
        logic        bad_operand;
    } t_res;

    // memory request from the decoder
    typedef struct packed {
        logic        wr;
        logic        word;
        logic        rd;
        logic [15:0] addr;
        logic [15:0] addr_nx;
        logic [15:0] wdata;
    } t_mreq;

    // complete plan for one instruction
    typedef struct packed {
        logic        is_load;
        logic        bw_en;
        logic [2:0]  bw_idx;
        logic [7:0]  bw_val;
        logic        pw_en;
        logic [1:0]  pw_idx;
        logic [15:0] pw_val;
        logic        fw_en;
        logic [7:0]  fw_val;
        t_mreq       mreq;
        t_res        res;
    } t_plan;

    // read a register pair, sp for pair 3
    function automatic logic [15:0] pair_get(t_regs regs, logic [15:0] sp, logic [1:0] p);
        logic [15:0] v;
        if (p == PAIR_SP) begin
            v = sp;
        end else begin
            v = {regs[{p, 1'b0}], regs[{p, 1'b1}]};
        end
        return v;
    endfunction

endpackage

[hw/rtl/lie_mem.sv]
// load instruction executor: byte memory split into even and odd banks
// with a registered read and a clearing sweep after reset; uses lie_pkg
module lie_mem #(
    parameter int ADDR_BITS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lie_pkg::t_mreq i_req,
    output logic [7:0]     o_rdata,
    output logic           o_busy
);

    localparam int IDX_BITS = ADDR_BITS - 1;
    localparam int DEPTH    = 1 << IDX_BITS;

    logic [7:0] r_bank0 [DEPTH];
    logic [7:0] r_bank1 [DEPTH];

    logic                r_clearing;
    logic [IDX_BITS-1:0] r_clr_idx;
    logic [7:0]          r_rd0;
    logic [7:0]          r_rd1;
    logic                r_rd_sel;

    logic                lo_odd;
    logic [IDX_BITS-1:0] idx_lo;
    logic [IDX_BITS-1:0] idx_nx;
    logic                we0, we1;
    logic [IDX_BITS-1:0] widx0, widx1;
    logic [7:0]          wd0, wd1;

    assign lo_odd = i_req.addr[0];
    assign idx_lo = i_req.addr[ADDR_BITS-1:1];
    assign idx_nx = i_req.addr_nx[ADDR_BITS-1:1];

    // bank steering: a word always hits both banks
    always_comb begin
        if (r_clearing) begin
            we0   = 1'b1;
            we1   = 1'b1;
            widx0 = r_clr_idx;
            widx1 = r_clr_idx;
            wd0   = 8'h00;
            wd1   = 8'h00;
        end else begin
            we0   = i_req.wr && (i_req.word || !lo_odd);
            we1   = i_req.wr && (i_req.word || lo_odd);
            widx0 = lo_odd ? idx_nx : idx_lo;
            widx1 = lo_odd ? idx_lo : idx_nx;
            wd0   = lo_odd ? i_req.wdata[15:8] : i_req.wdata[7:0];
            wd1   = lo_odd ? i_req.wdata[7:0] : i_req.wdata[15:8];
        end
    end

    // even bank
    always_ff @(posedge i_clk) begin
        if (we0) begin
            r_bank0[widx0] <= wd0;
        end
        r_rd0 <= r_bank0[idx_lo];
    end

    // odd bank
    always_ff @(posedge i_clk) begin
        if (we1) begin
            r_bank1[widx1] <= wd1;
        end
        r_rd1 <= r_bank1[idx_lo];
    end

    // bank select for the returning byte
    always_ff @(posedge i_clk) begin
        r_rd_sel <= lo_odd;
    end

    // clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == {IDX_BITS{1'b1}}) begin
                r_clearing <= 1'b0;
            end
        end
    end

    assign o_rdata = r_rd_sel ? r_rd1 : r_rd0;
    assign o_busy  = r_clearing;

endmodule

[hw/rtl/lie_dec.sv]
// load instruction executor: decodes one instruction against the current
// register file into register writes, a memory request and a result; uses lie_pkg
module lie_dec #(
    parameter int ADDR_BITS = 16
) (
    input  logic [4:0]     i_op,
    input  logic [2:0]     i_dest_select,
    input  logic [2:0]     i_source_select,
    input  logic [15:0]    i_immediate,
    input  lie_pkg::t_regs i_regs,
    input  logic [15:0]    i_sp,
    output lie_pkg::t_plan o_plan
);

    localparam logic [15:0] AMASK = 16'((17'd1 << ADDR_BITS) - 17'd1);

    logic [7:0]  imm8;
    logic [7:0]  f_cur;
    logic [7:0]  src_b;
    logic [15:0] hl;
    logic [15:0] high_addr;
    logic [15:0] dpair;
    logic [15:0] spair;
    logic [4:0]  nib_sum;
    logic [8:0]  byte_sum;
    logic [15:0] sp_off;
    logic [15:0] addr;

    assign imm8      = i_immediate[7:0];
    assign f_cur     = i_regs[lie_pkg::REG_F];
    assign src_b     = i_regs[i_source_select];
    assign hl        = lie_pkg::pair_get(i_regs, i_sp, lie_pkg::PAIR_HL);
    assign high_addr = lie_pkg::HIGH_PAGE + {8'h00, i_regs[lie_pkg::REG_C]};
    assign dpair     = lie_pkg::pair_get(i_regs, i_sp, i_dest_select[1:0]);
    assign spair     = lie_pkg::pair_get(i_regs, i_sp, i_source_select[1:0]);
    assign nib_sum   = {1'b0, i_sp[3:0]} + {1'b0, imm8[3:0]};
    assign byte_sum  = {1'b0, i_sp[7:0]} + {1'b0, imm8};
    assign sp_off    = i_sp + {{8{imm8[7]}}, imm8};

    // per-form decode
    always_comb begin
        o_plan = '0;
        addr   = 16'h0000;
        o_plan.res.flags = f_cur[7:4];
        unique case (i_op)
            lie_pkg::OP_ST_A16_SP: begin
                addr = i_immediate & AMASK;
                o_plan.mreq.wr    = 1'b1;
                o_plan.mreq.word  = 1'b1;
                o_plan.mreq.wdata = i_sp;
                o_plan.res.mem_access = lie_pkg::ACC_WORD;
                o_plan.res.mem_value  = i_sp;
            end
            lie_pkg::OP_ST_A16_R, lie_pkg::OP_ST_HIGH_R: begin
                addr = ((i_op == lie_pkg::OP_ST_A16_R) ? i_immediate : high_addr) & AMASK;
                o_plan.mreq.wr    = 1'b1;
                o_plan.mreq.wdata = {8'h00, src_b};
                o_plan.res.mem_access = lie_pkg::ACC_BYTE;
                o_plan.res.mem_value  = {8'h00, src_b};
            end
            lie_pkg::OP_ST_HLD_R, lie_pkg::OP_ST_HLI_R: begin
                addr = hl & AMASK;
                o_plan.mreq.wr    = 1'b1;
                o_plan.mreq.wdata = {8'h00, src_b};
                o_plan.pw_en  = 1'b1;
                o_plan.pw_idx = lie_pkg::PAIR_HL;
                o_plan.pw_val = (i_op == lie_pkg::OP_ST_HLI_R) ? hl + 16'd1 : hl - 16'd1;
                o_plan.res.mem_access = lie_pkg::ACC_BYTE;
                o_plan.res.mem_value  = {8'h00, src_b};
            end
            lie_pkg::OP_LD_RR_D16, lie_pkg::OP_LD_RR_RR, lie_pkg::OP_LD_RR_SPE: begin
                if (i_dest_select[2] || (i_op == lie_pkg::OP_LD_RR_RR && i_source_select[2])) begin
                    o_plan.res.bad_operand = 1'b1;
                end else begin
                    o_plan.pw_en  = 1'b1;
                    o_plan.pw_idx = i_dest_select[1:0];
                    if (i_op == lie_pkg::OP_LD_RR_D16) begin
                        o_plan.pw_val = i_immediate;
                    end else if (i_op == lie_pkg::OP_LD_RR_RR) begin
                        o_plan.pw_val = spair;
                    end else begin
                        o_plan.pw_val = sp_off;
                        o_plan.fw_en  = 1'b1;
                        o_plan.fw_val = {2'b00, nib_sum[4], byte_sum[8], f_cur[3:0]};
                        o_plan.res.flags = {2'b00, nib_sum[4], byte_sum[8]};
                    end
                    o_plan.res.dest_value = o_plan.pw_val;
                end
            end
            lie_pkg::OP_ST_RR_D8, lie_pkg::OP_ST_RR_R: begin
                if (i_dest_select[2]) begin
                    o_plan.res.bad_operand = 1'b1;
                end else begin
                    addr = dpair & AMASK;
                    o_plan.mreq.wr    = 1'b1;
                    o_plan.mreq.wdata = {8'h00, (i_op == lie_pkg::OP_ST_RR_D8) ? imm8 : src_b};
                    o_plan.res.mem_access = lie_pkg::ACC_BYTE;
                    o_plan.res.mem_value  = o_plan.mreq.wdata;
                end
            end
            lie_pkg::OP_LD_R_A16, lie_pkg::OP_LD_R_HLD, lie_pkg::OP_LD_R_HLI,
            lie_pkg::OP_LD_R_RR, lie_pkg::OP_LD_R_HIGH: begin
                if (i_op == lie_pkg::OP_LD_R_RR && i_source_select[2]) begin
                    o_plan.res.bad_operand = 1'b1;
                end else begin
                    if (i_op == lie_pkg::OP_LD_R_A16) begin
                        addr = i_immediate & AMASK;
                    end else if (i_op == lie_pkg::OP_LD_R_RR) begin
                        addr = spair & AMASK;
                    end else if (i_op == lie_pkg::OP_LD_R_HIGH) begin
                        addr = high_addr & AMASK;
                    end else begin
                        addr = hl & AMASK;
                        o_plan.pw_en  = 1'b1;
                        o_plan.pw_idx = lie_pkg::PAIR_HL;
                        o_plan.pw_val = (i_op == lie_pkg::OP_LD_R_HLI) ? hl + 16'd1 : hl - 16'd1;
                    end
                    o_plan.is_load = 1'b1;
                    o_plan.mreq.rd = 1'b1;
                    o_plan.bw_idx  = i_dest_select;
                    o_plan.res.mem_access = lie_pkg::ACC_READ;
                end
            end
            lie_pkg::OP_LD_R_D8, lie_pkg::OP_LD_R_R: begin
                o_plan.bw_en  = 1'b1;
                o_plan.bw_idx = i_dest_select;
                o_plan.bw_val = (i_op == lie_pkg::OP_LD_R_D8) ? imm8 : src_b;
                o_plan.res.dest_value = {8'h00, o_plan.bw_val};
                if (i_dest_select == lie_pkg::REG_F) begin
                    o_plan.res.flags = o_plan.bw_val[7:4];
                end
            end
            default: begin
                o_plan.res.bad_operand = 1'b1;
            end
        endcase
        o_plan.mreq.addr     = addr;
        o_plan.mreq.addr_nx  = (addr + 16'd1) & AMASK;
        o_plan.res.mem_address = (o_plan.mreq.wr || o_plan.mreq.rd) ? addr : 16'h0000;
    end

endmodule

[hw/rtl/load_instruction_executor_top.sv]
// load instruction executor top level: register file, load completion stage
// and two-entry result queue around lie_dec and lie_mem; uses lie_pkg
//
//  channel  | direction | tdata fields (lsb first)                          | tuser
//  s_axis   | in        | op[4:0] dest_select[7:5] source_select[10:8]      | -
//           |           | immediate[26:11], zero pad to 32                  |
//  m_axis   | out       | mem_access[1:0] mem_address[17:2] mem_value[33:18] | bad_operand
//           |           | dest_value[49:34] flags[53:50], zero pad to 56    |
//
// one instruction per cycle while s_axis_tready is high; a memory read form blocks the
// next instruction as the loaded byte returns from the memory port in the cycle after
// the address; a word store writes both byte banks in the same cycle
// after reset the memory is swept to zero with s_axis_tready low
// the result queue holds two transactions, so input keeps flowing after the output
// stalls until the queue is full
module load_instruction_executor_top #(
    parameter int ADDR_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // op, dest_select, source_select, immediate
    input  logic [lie_pkg::IN_BITS-1:0]  s_axis_tdata,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // mem_access, mem_address, mem_value, dest_value, flags
    output logic [lie_pkg::OUT_BITS-1:0] m_axis_tdata,
    // bad_operand
    output logic                         m_axis_tuser
);

    lie_pkg::t_regs  r_regs;
    logic [15:0]     r_sp;
    logic            r_ld_pend;
    logic [2:0]      r_ld_dest;
    lie_pkg::t_res   r_ld_res;
    lie_pkg::t_res   r_q [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;

    lie_pkg::t_plan  plan;
    lie_pkg::t_mreq  mreq;
    lie_pkg::t_res   ld_res;
    lie_pkg::t_res   push_res;
    lie_pkg::t_res   head;
    logic [7:0]      rdata;
    logic            mem_busy;
    logic            accept;
    logic            push;
    logic            pop;

    lie_dec #(.ADDR_BITS(ADDR_BITS)) u_dec (
        .i_op            (s_axis_tdata[4:0]),
        .i_dest_select   (s_axis_tdata[7:5]),
        .i_source_select (s_axis_tdata[10:8]),
        .i_immediate     (s_axis_tdata[26:11]),
        .i_regs          (r_regs),
        .i_sp            (r_sp),
        .o_plan          (plan)
    );

    // memory writes only on an accepted transaction
    always_comb begin
        mreq    = plan.mreq;
        mreq.wr = plan.mreq.wr && accept;
    end

    lie_mem #(.ADDR_BITS(ADDR_BITS)) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mreq),
        .o_rdata (rdata),
        .o_busy  (mem_busy)
    );

    // handshake
    assign s_axis_tready = !mem_busy && !r_ld_pend && (r_cnt != 2'd2);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign pop           = (r_cnt != 2'd0) && m_axis_tready;
    assign push          = (accept && !plan.is_load) || r_ld_pend;

    // completion of a memory read
    always_comb begin
        ld_res            = r_ld_res;
        ld_res.mem_value  = {8'h00, rdata};
        ld_res.dest_value = {8'h00, rdata};
        if (r_ld_dest == lie_pkg::REG_F) begin
            ld_res.flags = rdata[7:4];
        end
    end

    assign push_res = r_ld_pend ? ld_res : plan.res;

    // register file and sp
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= '0;
            r_sp   <= 16'h0000;
        end else begin
            if (accept && plan.pw_en) begin
                if (plan.pw_idx == lie_pkg::PAIR_SP) begin
                    r_sp <= plan.pw_val;
                end else begin
                    r_regs[{plan.pw_idx, 1'b0}] <= plan.pw_val[15:8];
                    r_regs[{plan.pw_idx, 1'b1}] <= plan.pw_val[7:0];
                end
            end
            if (accept && plan.bw_en) begin
                r_regs[plan.bw_idx] <= plan.bw_val;
            end
            if (accept && plan.fw_en) begin
                r_regs[lie_pkg::REG_F] <= plan.fw_val;
            end
            // loaded byte lands after any hl step of the same instruction
            if (r_ld_pend) begin
                r_regs[r_ld_dest] <= rdata;
            end
        end
    end

    // load completion stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ld_pend <= 1'b0;
        end else begin
            r_ld_pend <= accept && plan.is_load;
        end
        r_ld_dest <= plan.bw_idx;
        r_ld_res  <= plan.res;
    end

    // result queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= push_res;
        end
    end

    // output packing
    assign head          = r_q[r_rp];
    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tuser  = head.bad_operand;
    assign m_axis_tdata  = {2'b00, head.flags, head.dest_value, head.mem_value,
                            head.mem_address, head.mem_access};

endmodule

[hw/rtl/lie_chk.sv]
// load instruction executor: port-level checker bound to the top level
// depends on lie_pkg for widths and access codes
module lie_chk #(
    parameter int ADDR_BITS = 16
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic [lie_pkg::IN_BITS-1:0]  s_axis_tdata,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [lie_pkg::OUT_BITS-1:0] m_axis_tdata,
    input logic                         m_axis_tuser
);

    logic [1:0]  acc;
    logic [15:0] addr;
    logic [15:0] mval;
    logic [15:0] dval;

    assign acc  = m_axis_tdata[1:0];
    assign addr = m_axis_tdata[17:2];
    assign mval = m_axis_tdata[33:18];
    assign dval = m_axis_tdata[49:34];

    // an accepted instruction transaction carries no unknown bits
    a_in_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |-> !$isunknown(s_axis_tdata))
        else $error("unknown bits in accepted instruction");

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // a rejected instruction reports nothing but flags
    a_bad_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[49:0] == 50'd0)
        else $error("rejected instruction carries data");

    // a byte read puts the loaded byte in the destination
    a_read_dest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && acc == lie_pkg::ACC_READ |-> dval == mval && mval[15:8] == 8'h00)
        else $error("byte read value mismatch");

    // addresses stay inside the memory
    a_addr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (32'(addr) >> ADDR_BITS) == 32'd0)
        else $error("address beyond memory");

endmodule

bind load_instruction_executor_top lie_chk #(.ADDR_BITS(ADDR_BITS)) u_lie_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
